>>> rtl/lrpb_pkg.sv
// Shared types, register indexes and reset values of the local rank pixel binarizer.
package lrpb_pkg;

    localparam int DEF_MAX_WINDOW = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_RANK_INDEX   = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } cfg_reg_t;

    localparam logic [3:0]  RST_WINDOW_SIZE  = 4'd8;
    localparam logic [5:0]  RST_RANK_INDEX   = 6'd32;
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic issue;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_band;
        logic scan_last;
        logic out_busy;
    } dp_status_t;

endpackage

>>> rtl/lrpb_ram.sv
// Generic single-write, single-read memory with registered read data.
module lrpb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lrpb_ctrl.sv
// Controller state machine sequencing accept, window scan and result hand-off.
module lrpb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  lrpb_pkg::dp_status_t status,
    output lrpb_pkg::ctrl_cmd_t  cmd
);
    import lrpb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.in_band ? ST_SCAN : ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.accept   = in_valid;
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_EMIT:
            begin
                cmd.load_out = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/lrpb_dp.sv
// Datapath: configuration, frame counters, line store, window scan and output register.
module lrpb_dp #(
    parameter int MAX_WINDOW = lrpb_pkg::DEF_MAX_WINDOW,
    parameter int MAX_WIDTH  = lrpb_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = lrpb_pkg::DEF_PIXEL_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [lrpb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lrpb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [PIXEL_BITS-1:0]               pixel_value,
    input  logic                                mask_bit,
    input  logic                                out_ready,
    input  lrpb_pkg::ctrl_cmd_t                 cmd,
    output lrpb_pkg::dp_status_t                status,
    output logic                                out_valid,
    output logic                                bin_out,
    output logic                                frame_end
);
    import lrpb_pkg::*;

    localparam int RING  = MAX_WINDOW + 1;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int ADDRW = $clog2(DEPTH);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int WINW  = $clog2(MAX_WINDOW + 1);
    localparam int RNGW  = $clog2(RING);
    localparam int CNTW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

    logic [3:0]  window_size_reg;
    logic [5:0]  rank_index_reg;
    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;

    logic [15:0]     row_reg;
    logic [COLW-1:0] col_reg;
    logic [RNGW-1:0] ring_reg;

    logic [PIXEL_BITS-1:0] pix_reg;
    logic                  inside_reg;
    logic                  fend_reg;
    logic [CNTW-1:0]       need_reg;
    logic [CNTW-1:0]       below_reg;
    logic [WINW-1:0]       step_reg;
    logic [WINW-1:0]       r_idx_reg;
    logic [WINW-1:0]       c_idx_reg;
    logic [RNGW-1:0]       rd_row_reg;
    logic [COLW-1:0]       rd_col_reg;
    logic [COLW-1:0]       col_start_reg;
    logic                  rd_valid_reg;

    logic                  out_valid_reg;
    logic                  bin_reg;
    logic                  fend_out_reg;

    logic [WINW-1:0]       step_eff;
    logic [COLW:0]         width_eff;
    logic [16:0]           height_eff;
    logic [31:0]           sq_last;
    logic [31:0]           rank_eff;
    logic                  inside_now;
    logic                  col_end;
    logic                  row_end;
    logic [RNGW-1:0]       start_row;
    logic [PIXEL_BITS-1:0] rdata;
    logic [ADDRW-1:0]      waddr;
    logic [ADDRW-1:0]      raddr;

    // Effective register values, with out-of-range settings clamped.
    always_comb
    begin
        if (window_size_reg == 4'd0)
        begin
            step_eff = WINW'(1);
        end
        else if (32'(window_size_reg) > 32'(MAX_WINDOW))
        begin
            step_eff = WINW'(MAX_WINDOW);
        end
        else
        begin
            step_eff = WINW'(window_size_reg);
        end

        if (image_width_reg == 11'd0)
        begin
            width_eff = (COLW + 1)'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            width_eff = (COLW + 1)'(MAX_WIDTH);
        end
        else
        begin
            width_eff = (COLW + 1)'(image_width_reg);
        end

        height_eff = (image_height_reg == 16'd0) ? 17'd1 : {1'b0, image_height_reg};

        sq_last  = 32'(step_eff) * 32'(step_eff) - 32'd1;
        rank_eff = (32'(rank_index_reg) > sq_last) ? sq_last : 32'(rank_index_reg);

        inside_now = mask_bit
                     && (32'(row_reg) >= 32'(step_eff))
                     && ((32'(row_reg) + 32'(step_eff)) < 32'(height_eff))
                     && (32'(col_reg) >= 32'(step_eff))
                     && ((32'(col_reg) + 32'(step_eff)) < 32'(width_eff));

        col_end = (32'(col_reg) + 32'd1) >= 32'(width_eff);
        row_end = (32'(row_reg) + 32'd1) >= 32'(height_eff);

        // Oldest window row in the ring, taken modulo the ring depth.
        if (32'(ring_reg) >= 32'(step_eff))
        begin
            start_row = RNGW'(32'(ring_reg) - 32'(step_eff));
        end
        else
        begin
            start_row = RNGW'(32'(ring_reg) + 32'(RING) - 32'(step_eff));
        end

        waddr = ADDRW'(32'(ring_reg) * 32'(MAX_WIDTH) + 32'(col_reg));
        raddr = ADDRW'(32'(rd_row_reg) * 32'(MAX_WIDTH) + 32'(rd_col_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= RST_WINDOW_SIZE;
            rank_index_reg   <= RST_RANK_INDEX;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_SIZE:  window_size_reg  <= cfg_data[3:0];
                REG_RANK_INDEX:   rank_index_reg   <= cfg_data[5:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[15:0];
                default:          window_size_reg  <= window_size_reg;
            endcase
        end
    end

    // Frame position and ring row advance at accept time; the pixel is
    // written then too, since its row never lies inside its own window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            ring_reg     <= '0;
            rd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.issue;
            if (cmd.accept)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    if (row_end)
                    begin
                        row_reg  <= '0;
                        ring_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= row_reg + 16'd1;
                        ring_reg <= (32'(ring_reg) == 32'(MAX_WINDOW)) ? '0
                                                                        : ring_reg + RNGW'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + COLW'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg       <= pixel_value;
            inside_reg    <= inside_now;
            fend_reg      <= col_end && row_end;
            need_reg      <= CNTW'(rank_eff + 32'd1);
            below_reg     <= '0;
            step_reg      <= step_eff;
            r_idx_reg     <= '0;
            c_idx_reg     <= '0;
            rd_row_reg    <= start_row;
            rd_col_reg    <= COLW'(32'(col_reg) - 32'(step_eff));
            col_start_reg <= COLW'(32'(col_reg) - 32'(step_eff));
        end
        else
        begin
            if (cmd.issue)
            begin
                if (c_idx_reg == step_reg - WINW'(1))
                begin
                    c_idx_reg  <= '0;
                    r_idx_reg  <= r_idx_reg + WINW'(1);
                    rd_col_reg <= col_start_reg;
                    rd_row_reg <= (32'(rd_row_reg) == 32'(MAX_WINDOW)) ? '0
                                                                        : rd_row_reg + RNGW'(1);
                end
                else
                begin
                    c_idx_reg  <= c_idx_reg + WINW'(1);
                    rd_col_reg <= rd_col_reg + COLW'(1);
                end
            end
            if (rd_valid_reg && (rdata < pix_reg))
            begin
                below_reg <= below_reg + CNTW'(1);
            end
        end
        if (cmd.load_out)
        begin
            bin_reg      <= inside_reg && (below_reg >= need_reg);
            fend_out_reg <= fend_reg;
        end
    end

    lrpb_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (waddr),
        .wdata (pixel_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.in_band   = inside_now;
    assign status.scan_last = (r_idx_reg == step_reg - WINW'(1))
                              && (c_idx_reg == step_reg - WINW'(1));
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign bin_out   = bin_reg;
    assign frame_end = fend_out_reg;

endmodule

>>> rtl/local_rank_pixel_binarizer_core.sv
// Top level of the local rank pixel binarizer.
// Pixels enter in raster order on the in channel (pixel_value, mask_bit) and
// each gives one beat on the out channel (bin_out, frame_end). bin_out is 1
// when the mask is set, the pixel lies inside the border band and it exceeds
// the rank-th smallest value of the s-by-s window of earlier pixels above and
// to the left. frame_end marks the last pixel of a frame.
// The cfg channel writes window_size, rank_index, image_width and image_height
// (indexes 0 to 3); it is always ready and should be used while idle.
// A pixel inside the band has its window read from the line store one value
// per cycle through a single read port, followed by a drain state in which
// the last read is counted, before its result is loaded into the output
// register; a pixel outside the band goes straight to the load. The load
// waits while the receiver has not yet taken the previous beat. No new pixel
// is accepted before the previous result is loaded; one can be accepted in
// the cycle after, so a stalled receiver holds one finished beat while
// the next pixel is already being worked on. Reset returns the registers to
// their defaults and the frame position to row 0, column 0; the line store is
// not cleared, as only rows of the current frame are ever read.
module local_rank_pixel_binarizer_core #(
    parameter int MAX_WINDOW = lrpb_pkg::DEF_MAX_WINDOW,
    parameter int MAX_WIDTH  = lrpb_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = lrpb_pkg::DEF_PIXEL_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrpb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lrpb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [PIXEL_BITS-1:0]               pixel_value,
    input  logic                                mask_bit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                bin_out,
    output logic                                frame_end
);
    import lrpb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    lrpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd)
    );

    lrpb_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_value (pixel_value),
        .mask_bit    (mask_bit),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .bin_out     (bin_out),
        .frame_end   (frame_end)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = cmd.in_ready;

endmodule
